// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ramr_pkg.sv
// shared types, constants and helper functions of the rational add/multiply unit
// no dependencies; imported by every module of the block
`default_nettype none

package ramr_pkg;

  localparam int OPERAND_BITS = 32;
  localparam int IN_W         = 32;
  localparam int MAG_W        = 2 * OPERAND_BITS;
  localparam int KCNT_W       = $clog2(MAG_W);
  localparam int DCNT_W       = $clog2(MAG_W);
  localparam int RES_NUM_W    = 64;
  localparam int RES_DEN_W    = 63;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  localparam logic [RES_NUM_W-1:0] NUM_MAX = {1'b0, {(RES_NUM_W-1){1'b1}}};

  typedef struct packed {
    logic                   command;
    logic signed [IN_W-1:0] a_num;
    logic signed [IN_W-1:0] a_den;
    logic signed [IN_W-1:0] b_num;
    logic signed [IN_W-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] result_num;
    logic        [RES_DEN_W-1:0] result_den;
    logic                        invalid;
  } out_item_t;

  // sign-magnitude operand
  typedef struct packed {
    logic                    neg;
    logic [OPERAND_BITS-1:0] mag;
  } sm_op_t;

  // sign-magnitude wide value
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } smag_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_DEN,
    S_MUL_X,
    S_MUL_Y,
    S_SUM,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } seq_state_t;

  function automatic sm_op_t to_smag(logic [IN_W-1:0] raw);
    sm_op_t r;
    logic [OPERAND_BITS-1:0] w;
    w     = raw[OPERAND_BITS-1:0];
    r.neg = w[OPERAND_BITS-1];
    r.mag = r.neg ? (~w + 1'b1) : w;
    return r;
  endfunction

  function automatic smag_t sm_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ramr_mul.sv
// shared operand multiplier with registered product
// depends on ramr_pkg
`default_nettype none

module ramr_mul (
  input  logic                              clk,
  input  logic [ramr_pkg::OPERAND_BITS-1:0] a_i,
  input  logic [ramr_pkg::OPERAND_BITS-1:0] b_i,
  output logic [ramr_pkg::MAG_W-1:0]        p_r
);
  import ramr_pkg::*;

  logic [MAG_W-1:0] p_nxt;

  assign p_nxt = a_i * b_i;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/ramr_gcd.sv
// binary gcd, one reduction step per cycle, for two nonzero magnitudes
// depends on ramr_pkg
`default_nettype none

module ramr_gcd (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [ramr_pkg::MAG_W-1:0] x_i,
  input  logic [ramr_pkg::MAG_W-1:0] y_i,
  output logic [ramr_pkg::MAG_W-1:0] g_r,
  output ramr_pkg::unit_sts_t        sts_o
);
  import ramr_pkg::*;

  logic [MAG_W-1:0]  u_r, v_r, u_nxt, v_nxt;
  logic [KCNT_W-1:0] k_r, k_nxt;
  logic              busy_r, done_r;
  logic [MAG_W-1:0]  d_uv, d_vu;
  logic              fin;

  assign d_uv = u_r - v_r;
  assign d_vu = v_r - u_r;
  assign fin  = busy_r && (u_r == v_r);

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    if (!u_r[0] && !v_r[0]) begin
      // common factor of two
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r > v_r) begin
      u_nxt = d_uv >> 1;
    end else begin
      v_nxt = d_vu >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      u_r <= x_i;
      v_r <= y_i;
      k_r <= '0;
    end else if (busy_r && !fin) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end
    if (fin) g_r <= u_r << k_r;
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;

endmodule

`default_nettype wire

// File: rtl/ramr_div.sv
// restoring divider, one quotient bit per cycle
// depends on ramr_pkg
`default_nettype none

module ramr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [ramr_pkg::MAG_W-1:0] n_i,
  input  logic [ramr_pkg::MAG_W-1:0] d_i,
  output logic [ramr_pkg::MAG_W-1:0] q_r,
  output ramr_pkg::unit_sts_t        sts_o
);
  import ramr_pkg::*;

  localparam logic [DCNT_W-1:0] LAST = DCNT_W'(MAG_W - 1);

  logic [MAG_W-1:0]  r_r, d_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [MAG_W:0]    rs, diff;
  logic              qbit;
  logic              last;

  assign rs   = {r_r, q_r[MAG_W-1]};
  assign diff = rs - {1'b0, d_r};
  assign qbit = !diff[MAG_W];
  assign last = busy_r && (cnt_r == LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      q_r   <= n_i;
      d_r   <= d_i;
      r_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[MAG_W-2:0], qbit};
      r_r   <= qbit ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;

endmodule

`default_nettype wire

// File: rtl/rational_add_multiply_reduce_unit.sv
// top level of the rational add/multiply unit with reduction to lowest terms
// depends on ramr_pkg, ramr_mul, ramr_gcd, ramr_div and assert_macros.svh
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------
//   in_     | in  | in_valid / in_stall  | in_item_t  command, a/b num, den
//   out_    | out | out_valid / out_stall| out_item_t result_num, den, flag
//
// when a denominator or the numerator is zero an item skips the gcd and divide
// steps; otherwise the binary gcd loop runs once and the bit-serial divider runs
// twice, once for the numerator and once for the denominator, and these set how
// long an item takes
// reset is synchronous, active low, and clears the sequencer and result valid
// in_stall is high from each transfer until its result is in the output register;
// the next item is taken while that result still waits on out_stall
`default_nettype none

module rational_add_multiply_reduce_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ramr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ramr_pkg::out_item_t out_data
);
  import ramr_pkg::*;
  `include "assert_macros.svh"

  seq_state_t state_r, state_nxt;

  // captured operands
  logic   cmd_r;
  sm_op_t an_r, ad_r, bn_r, bd_r;
  logic   den_neg_r;

  // products and sums
  logic [MAG_W-1:0] den_mag_r;
  smag_t            t1_r, py, num_r;
  logic             x_neg;

  // reduced magnitudes
  logic [MAG_W-1:0] nm_r, dm_r;

  // shared multiplier
  logic [OPERAND_BITS-1:0] mul_a, mul_b;
  logic [MAG_W-1:0]        mul_p;

  // iterative units
  logic             gcd_start, div_start;
  logic [MAG_W-1:0] gcd_g, div_n, div_q;
  unit_sts_t        gcd_sts, div_sts;

  // output register
  logic      out_valid_r;
  out_item_t out_r, out_nxt;
  logic      out_load;
  logic [RES_NUM_W-1:0] nm_ext;
  logic                 res_neg;

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  ramr_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_r (mul_p)
  );

  ramr_gcd u_gcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (gcd_start),
    .x_i     (num_r.mag),
    .y_i     (den_mag_r),
    .g_r     (gcd_g),
    .sts_o   (gcd_sts)
  );

  ramr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (gcd_g),
    .q_r     (div_q),
    .sts_o   (div_sts)
  );

  // sign of the first cross product (or the only product when multiplying)
  assign x_neg = (cmd_r == CMD_MUL) ? (an_r.neg ^ bn_r.neg) : (ad_r.neg ^ bn_r.neg);

  // second cross product as it leaves the multiplier
  assign py.mag = mul_p;
  assign py.neg = (mul_p != '0) && (bd_r.neg ^ an_r.neg);

  // sequencer register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit control
  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    mul_a     = ad_r.mag;
    mul_b     = bd_r.mag;
    gcd_start = 1'b0;
    div_start = 1'b0;
    div_n     = num_r.mag;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        // denominator product goes first
        state_nxt = S_MUL_X;
      end
      S_MUL_X: begin
        mul_a     = (cmd_r == CMD_MUL) ? an_r.mag : ad_r.mag;
        mul_b     = bn_r.mag;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        mul_a     = bd_r.mag;
        mul_b     = an_r.mag;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // zero denominator or zero numerator skip the reduction
        if (den_mag_r == '0 || num_r.mag == '0) begin
          state_nxt = S_FIN;
        end else begin
          gcd_start = 1'b1;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (gcd_sts.done) begin
          div_start = 1'b1;
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_sts.done) begin
          div_n     = den_mag_r;
          div_start = 1'b1;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_sts.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to be free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r     <= in_data.command;
      an_r      <= to_smag(in_data.a_num);
      ad_r      <= to_smag(in_data.a_den);
      bn_r      <= to_smag(in_data.b_num);
      bd_r      <= to_smag(in_data.b_den);
      den_neg_r <= to_smag(in_data.a_den).neg ^ to_smag(in_data.b_den).neg;
    end
    if (state_r == S_MUL_X) den_mag_r <= mul_p;
    if (state_r == S_MUL_Y) begin
      t1_r.mag <= mul_p;
      t1_r.neg <= (mul_p != '0) && x_neg;
    end
    if (state_r == S_SUM) begin
      num_r <= (cmd_r == CMD_MUL) ? t1_r : sm_add(t1_r, py);
    end
    if (state_r == S_DIVN && div_sts.done) nm_r <= div_q;
    if (state_r == S_DIVD && div_sts.done) dm_r <= div_q;
  end

  // result formatting: sign on the numerator, saturate a positive overflow
  assign nm_ext  = RES_NUM_W'(nm_r);
  assign res_neg = num_r.neg ^ den_neg_r;

  always_comb begin
    if (den_mag_r == '0) begin
      out_nxt.result_num = '0;
      out_nxt.result_den = '0;
      out_nxt.invalid    = 1'b1;
    end else if (num_r.mag == '0) begin
      out_nxt.result_num = '0;
      out_nxt.result_den = RES_DEN_W'(1);
      out_nxt.invalid    = 1'b0;
    end else begin
      if (res_neg) begin
        out_nxt.result_num = -nm_ext;
      end else if (nm_ext[RES_NUM_W-1]) begin
        out_nxt.result_num = NUM_MAX;
      end else begin
        out_nxt.result_num = nm_ext;
      end
      out_nxt.result_den = RES_DEN_W'(dm_r);
      out_nxt.invalid    = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `ASSERT_NXT(a_accept_starts, clk, rst_n, in_xfer, state_r == S_MUL_DEN,
              "transfer did not start the products")
  `ASSERT_IMP(a_gcd_owned, clk, rst_n, gcd_sts.busy, state_r == S_GCD,
              "gcd running outside its step")
  `ASSERT_IMP(a_div_owned, clk, rst_n, div_sts.busy,
              state_r == S_DIVN || state_r == S_DIVD,
              "divider running outside its steps")
  `ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid_r && out_r.invalid,
              out_r.result_num == '0 && out_r.result_den == '0,
              "invalid result not 0/0")
  `ASSERT_IMP(a_den_nonzero, clk, rst_n, out_valid_r && !out_r.invalid,
              out_r.result_den != '0,
              "valid result with zero denominator")

endmodule

`default_nettype wire
